/* src/ckcm_pkg.sv */
// Shared types and constants for the corner keyed chroma mask unit.
package ckcm_pkg;

   localparam int unsigned CHAN_W   = 8;
   localparam int unsigned SUM_W    = 10;
   localparam int unsigned COUNT_W  = 3;
   localparam int unsigned THRESH_W = 18;

   localparam logic [THRESH_W-1:0] THRESH_RESET = 18'd3600;
   localparam logic [COUNT_W-1:0]  KEY_SAMPLES  = 3'd4;

   // Item kinds carried on the request tuser bit.
   localparam logic KIND_KEY   = 1'b0;
   localparam logic KIND_PIXEL = 1'b1;

   typedef struct packed {
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
   } rgb_type;

   typedef struct packed {
      logic    kind;
      logic    frame_end;
      rgb_type color;
   } item_type;

endpackage

/* src/corner_keyed_chroma_mask_unit.sv */
// Top level of the corner keyed chroma mask unit.
//
//   channel | direction | tdata (low bit up)        | side fields
//   req     | in        | red, green, blue (24 b)   | tuser = kind, tlast = frame end
//   rsp     | out       | opaque, zero fill (8 b)   | none
//   csr     | in        | distance threshold (18 b) | write enable only
//
// One transaction is accepted per cycle while request tready is high. A frame
// pixel passes one input register, then the distance compare into the output
// register. Key samples update the channel sums and produce no result.
// Reset clears the sums, the sample count and both valid flags and reloads the
// threshold. Request tready drops only while a pixel waits behind a stalled result.
module corner_keyed_chroma_mask_unit
   import ckcm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,

   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [23:0]         req_tdata,   // red [7:0], green [15:8], blue [23:16]
   input  logic                req_tuser,   // kind: 0 key sample, 1 frame pixel
   input  logic                req_tlast,   // frame end

   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,   // opaque [0], zero [7:1]

   input  logic                csr_we,
   input  logic [THRESH_W-1:0] csr_wdata
);

   logic                item_valid_ff, item_valid_in;
   item_type            item_ff;
   logic                out_valid_ff, out_valid_in;
   logic                opaque_ff, opaque_in;
   logic [THRESH_W-1:0] thresh_ff;
   logic [SUM_W-1:0]    red_sum_ff, green_sum_ff, blue_sum_ff;
   logic [SUM_W-1:0]    red_sum_in, green_sum_in, blue_sum_in;
   logic [COUNT_W-1:0]  count_ff, count_in;

   logic    req_accept;
   logic    item_advance;
   rgb_type key_color;

   // A key sample never needs the output register, so it always moves on.
   assign item_advance = item_valid_ff &&
      (item_ff.kind == KIND_KEY || !out_valid_ff || rsp_tready);
   assign req_tready   = !item_valid_ff || item_advance;
   assign req_accept   = req_tvalid && req_tready;

   assign item_valid_in = req_accept || (item_valid_ff && !item_advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff.kind      <= req_tuser;
         item_ff.frame_end <= req_tlast;
         item_ff.color     <= rgb_type'(req_tdata);
      end
   end

   assign key_color.red   = red_sum_ff[SUM_W-1:2];
   assign key_color.green = green_sum_ff[SUM_W-1:2];
   assign key_color.blue  = blue_sum_ff[SUM_W-1:2];

   ckcm_classify u_classify (
      .pixel     (item_ff.color),
      .key       (key_color),
      .threshold (thresh_ff),
      .opaque    (opaque_in)
   );

   always_comb begin
      red_sum_in   = red_sum_ff;
      green_sum_in = green_sum_ff;
      blue_sum_in  = blue_sum_ff;
      count_in     = count_ff;
      if (item_advance) begin
         if (item_ff.kind == KIND_KEY) begin
            if (count_ff >= KEY_SAMPLES) begin
               // A fifth sample starts a fresh set of sums.
               red_sum_in   = {2'b00, item_ff.color.red};
               green_sum_in = {2'b00, item_ff.color.green};
               blue_sum_in  = {2'b00, item_ff.color.blue};
               count_in     = COUNT_W'(1);
            end else begin
               red_sum_in   = red_sum_ff   + {2'b00, item_ff.color.red};
               green_sum_in = green_sum_ff + {2'b00, item_ff.color.green};
               blue_sum_in  = blue_sum_ff  + {2'b00, item_ff.color.blue};
               count_in     = count_ff + COUNT_W'(1);
            end
         end
         if (item_ff.frame_end) begin
            red_sum_in   = '0;
            green_sum_in = '0;
            blue_sum_in  = '0;
            count_in     = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         red_sum_ff   <= '0;
         green_sum_ff <= '0;
         blue_sum_ff  <= '0;
         count_ff     <= '0;
         thresh_ff    <= THRESH_RESET;
      end else begin
         red_sum_ff   <= red_sum_in;
         green_sum_ff <= green_sum_in;
         blue_sum_ff  <= blue_sum_in;
         count_ff     <= count_in;
         if (csr_we) begin
            thresh_ff <= csr_wdata;
         end
      end
   end

   assign out_valid_in = (item_advance && item_ff.kind == KIND_PIXEL) ||
                         (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_advance && item_ff.kind == KIND_PIXEL) begin
         opaque_ff <= opaque_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'b0000000, opaque_ff};

endmodule

/* src/ckcm_classify.sv */
// Squared-distance classifier: compares a pixel against the key color and black.
module ckcm_classify
   import ckcm_pkg::*;
(
   input  rgb_type             pixel,
   input  rgb_type             key,
   input  logic [THRESH_W-1:0] threshold,
   output logic                opaque
);

   logic [CHAN_W-1:0]   diff_r, diff_g, diff_b;
   logic [THRESH_W-1:0] key_dist;
   logic [THRESH_W-1:0] black_dist;

   always_comb begin
      diff_r = (pixel.red   >= key.red)   ? pixel.red   - key.red   : key.red   - pixel.red;
      diff_g = (pixel.green >= key.green) ? pixel.green - key.green : key.green - pixel.green;
      diff_b = (pixel.blue  >= key.blue)  ? pixel.blue  - key.blue  : key.blue  - pixel.blue;
   end

   // Each square fits 16 bits; three of them stay below 2^18.
   assign key_dist =
      {2'b00, 16'(diff_r * diff_r)} + {2'b00, 16'(diff_g * diff_g)} +
      {2'b00, 16'(diff_b * diff_b)};
   assign black_dist =
      {2'b00, 16'(pixel.red * pixel.red)} + {2'b00, 16'(pixel.green * pixel.green)} +
      {2'b00, 16'(pixel.blue * pixel.blue)};

   assign opaque = !((key_dist <= threshold) || (black_dist <= threshold));

endmodule

/* src/ckcm_checker.sv */
// Port-level assertions for the corner keyed chroma mask unit, with its bind.
module ckcm_checker
   import ckcm_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic req_tuser,
   input logic rsp_tvalid,
   input logic rsp_tready
);

   // A stalled result stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result withdrawn while stalled");

   // Reset leaves no result pending.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // A new result follows an earlier accepted pixel transaction.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |->
         $past(req_tvalid && req_tready && req_tuser == KIND_PIXEL, 2))
      else $error("result without a matching pixel transaction");

   // The request side only backs up behind a stalled result.
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("request stalled with the result side free");

endmodule

bind corner_keyed_chroma_mask_unit ckcm_checker u_ckcm_checker (.*);

/* sim/tb_corner_keyed_chroma_mask_unit.sv */
// Self-checking testbench for the corner keyed chroma mask unit.
`timescale 1ns / 100ps

module tb_corner_keyed_chroma_mask_unit
   import ckcm_pkg::*;
();

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned HOLD_CYCLES = 400;
   localparam int unsigned IDLE_PCT    = 22;

   logic                clock;
   logic                reset = 1'b1;

   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [23:0]         req_tdata = '0;    // red [7:0], green [15:8], blue [23:16]
   logic                req_tuser = 1'b0;  // kind
   logic                req_tlast = 1'b0;  // frame end

   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [7:0]          rsp_tdata;         // opaque [0], zero fill [7:1]

   logic                csr_we = 1'b0;
   logic [THRESH_W-1:0] csr_wdata = '0;

   corner_keyed_chroma_mask_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   // Predictor state: threshold, key sums and the number of key samples held.
   logic [THRESH_W-1:0] mask_threshold = THRESH_RESET;
   logic [SUM_W-1:0]    key_red_acc    = '0;
   logic [SUM_W-1:0]    key_green_acc  = '0;
   logic [SUM_W-1:0]    key_blue_acc   = '0;
   logic [COUNT_W-1:0]  key_count      = '0;

   item_type pending_items[$];
   logic     opaque_expected[$];
   item_type offered_item;

   logic        calm = 1'b0;
   int unsigned hold_requests = 0;
   int unsigned holds_taken = 0;
   int unsigned hold_left = 0;
   int unsigned cycle_count = 0;
   int unsigned mismatches = 0;
   int unsigned n_queued = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int unsigned sq_dist(input int r, input int g, input int b,
                                           input int kr, input int kg, input int kb);
      return (r - kr) * (r - kr) + (g - kg) * (g - kg) + (b - kb) * (b - kb);
   endfunction

   function automatic logic [7:0] jitter(input logic [7:0] base, input int spread);
      int v;
      v = int'(base) + int'($urandom_range(2 * spread)) - spread;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return v[7:0];
   endfunction

   task automatic clear_keys();
      key_red_acc   = '0;
      key_green_acc = '0;
      key_blue_acc  = '0;
      key_count     = '0;
   endtask

   // Updates the key sums for a sample or queues the expected mask bit for a pixel.
   task automatic predict_mask(input item_type it);
      int unsigned to_key;
      int unsigned to_black;
      if (it.kind == KIND_KEY) begin
         if (key_count >= KEY_SAMPLES) clear_keys();
         key_red_acc   = key_red_acc + SUM_W'(it.color.red);
         key_green_acc = key_green_acc + SUM_W'(it.color.green);
         key_blue_acc  = key_blue_acc + SUM_W'(it.color.blue);
         key_count     = key_count + COUNT_W'(1);
      end else begin
         to_key = sq_dist(int'(it.color.red), int'(it.color.green), int'(it.color.blue),
                          int'(key_red_acc) / 4, int'(key_green_acc) / 4,
                          int'(key_blue_acc) / 4);
         to_black = sq_dist(int'(it.color.red), int'(it.color.green),
                            int'(it.color.blue), 0, 0, 0);
         opaque_expected.push_back(!(to_key <= 32'(mask_threshold) ||
                                     to_black <= 32'(mask_threshold)));
      end
      if (it.frame_end) clear_keys();
   endtask

   task automatic push_item(input logic kind, input logic fend,
                            input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
      item_type it;
      it.kind        = kind;
      it.frame_end   = fend;
      it.color.red   = r;
      it.color.green = g;
      it.color.blue  = b;
      pending_items.push_back(it);
      n_queued++;
   endtask

   // One frame: corner samples around a base color, then pixels near the key,
   // near black or anywhere, closed by the frame end flag.
   task automatic add_frame();
      logic [7:0]  br, bg, bb;
      int unsigned n_keys, n_pix, roll, spread;
      logic        key_end;
      br = 8'($urandom_range(255));
      bg = 8'($urandom_range(255));
      bb = 8'($urandom_range(255));
      roll = $urandom_range(99);
      n_keys = (roll < 80) ? 4 : (roll < 90) ? 5 : $urandom_range(3);
      key_end = ($urandom_range(19) == 0);
      for (int unsigned k = 0; k < n_keys; k++)
         push_item(KIND_KEY, 1'b0, jitter(br, 6), jitter(bg, 6), jitter(bb, 6));
      n_pix = $urandom_range(1, 16);
      for (int unsigned p = 0; p < n_pix; p++) begin
         roll = $urandom_range(99);
         spread = $urandom_range(1, 70);
         if (roll < 40)
            push_item(KIND_PIXEL, !key_end && p == n_pix - 1,
                      jitter(br, spread), jitter(bg, spread), jitter(bb, spread));
         else if (roll < 55)
            push_item(KIND_PIXEL, !key_end && p == n_pix - 1,
                      8'($urandom_range(60)), 8'($urandom_range(60)),
                      8'($urandom_range(60)));
         else
            push_item(KIND_PIXEL, !key_end && p == n_pix - 1,
                      8'($urandom_range(255)), 8'($urandom_range(255)),
                      8'($urandom_range(255)));
      end
      if (key_end)
         push_item(KIND_KEY, 1'b1, 8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255)));
   endtask

   task automatic random_phase(input int unsigned target);
      int unsigned stop_at;
      stop_at = n_queued + target;
      while (n_queued < stop_at) begin
         if ($urandom_range(99) < 10)
            push_item(1'($urandom_range(1)), 1'($urandom_range(1)),
                      8'($urandom_range(255)), 8'($urandom_range(255)),
                      8'($urandom_range(255)));
         else
            add_frame();
      end
   endtask

   // Waits until every queued item is taken and every result has arrived, then
   // lets the pipeline settle in case a key sample is still in flight.
   task automatic wait_idle();
      while (pending_items.size() != 0 || req_tvalid || opaque_expected.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [THRESH_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      mask_threshold = value;
   endtask

   always @(posedge clock) begin : req_driver
      item_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) predict_mask(offered_item);
         if (!req_tvalid || req_tready) begin
            if (pending_items.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
               nxt = pending_items.pop_front();
               offered_item <= nxt;
               req_tdata    <= {nxt.color.blue, nxt.color.green, nxt.color.red};
               req_tuser    <= nxt.kind;
               req_tlast    <= nxt.frame_end;
               req_tvalid   <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // The receiver takes a long hold-off whenever one is requested.
   always @(posedge clock) begin : rsp_receiver
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (holds_taken != hold_requests) begin
         holds_taken <= holds_taken + 1;
         hold_left   <= HOLD_CYCLES;
         rsp_tready  <= 1'b0;
      end else begin
         rsp_tready <= calm || $urandom_range(99) >= IDLE_PCT;
      end
   end

   always @(posedge clock) begin : rsp_monitor
      logic want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (opaque_expected.size() == 0) begin
            $error("unexpected result transaction: opaque %0b", rsp_tdata[0]);
            mismatches++;
         end else begin
            want = opaque_expected.pop_front();
            if (rsp_tdata[0] !== want) begin
               $error("opaque mismatch: expected %0b, actual %0b", want, rsp_tdata[0]);
               mismatches++;
            end
            if (rsp_tdata[7:1] !== 7'd0) begin
               $error("zero fill mismatch: expected 0x00, actual 0x%02h", rsp_tdata[7:1]);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      logic [THRESH_W-1:0] thresholds[6];
      int unsigned         targets[6];
      thresholds = '{18'd3600, 18'd0, 18'd195075, 18'h3FFFF, 18'd0, 18'd1600};
      targets    = '{400, 250, 150, 150, 450, 450};
      thresholds[4] = THRESH_W'($urandom_range(20000));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the reset threshold. Pixels before any key sample
      // compare against a zero key.
      push_item(KIND_PIXEL, 1'b0, 8'd0, 8'd0, 8'd0);
      push_item(KIND_PIXEL, 1'b0, 8'd255, 8'd255, 8'd255);
      push_item(KIND_PIXEL, 1'b0, 8'd255, 8'd0, 8'd0);
      repeat (4) push_item(KIND_KEY, 1'b0, 8'd255, 8'd255, 8'd255);
      push_item(KIND_PIXEL, 1'b0, 8'd255, 8'd255, 8'd255);
      push_item(KIND_PIXEL, 1'b0, 8'd200, 8'd200, 8'd200);
      // A fifth key sample restarts the sums.
      push_item(KIND_KEY, 1'b0, 8'd0, 8'd255, 8'd0);
      push_item(KIND_PIXEL, 1'b0, 8'd0, 8'd63, 8'd0);
      push_item(KIND_KEY, 1'b0, 8'd40, 8'd40, 8'd40);
      push_item(KIND_PIXEL, 1'b0, 8'd10, 8'd73, 8'd10);
      // Frame end carried by a key sample clears everything after accumulating.
      push_item(KIND_KEY, 1'b1, 8'd0, 8'd0, 8'd0);
      push_item(KIND_PIXEL, 1'b0, 8'd30, 8'd30, 8'd30);
      push_item(KIND_PIXEL, 1'b1, 8'd35, 8'd35, 8'd35);
      push_item(KIND_PIXEL, 1'b0, 8'd34, 8'd34, 8'd35);
      push_item(KIND_KEY, 1'b0, 8'd255, 8'd0, 8'd255);
      push_item(KIND_KEY, 1'b0, 8'd255, 8'd0, 8'd255);
      push_item(KIND_PIXEL, 1'b1, 8'd127, 8'd0, 8'd127);
      push_item(KIND_PIXEL, 1'b0, 8'd255, 8'd255, 8'd0);
      wait_idle();

      for (int ph = 0; ph < 6; ph++) begin
         write_threshold(thresholds[ph]);
         calm = (ph == 0);
         if (ph == 4) hold_requests++;
         random_phase(targets[ph]);
         wait_idle();
         calm = 1'b0;
      end

      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

/* files.f */
src/ckcm_pkg.sv
src/ckcm_classify.sv
src/corner_keyed_chroma_mask_unit.sv
src/ckcm_checker.sv
sim/tb_corner_keyed_chroma_mask_unit.sv
